// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file kred_checker.sv
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- hdl/kred_pkg.sv -----
// shared types, constants and lookup tables of the keyboard report event decoder
// no dependencies
`default_nettype none

package kred_pkg;

   localparam int KEY_SLOTS    = 6;
   localparam int KEY_CODES_DEF = 256;
   localparam int MAX_RESULTS  = 26;

   localparam logic [15:0] DELAY_RESET  = 16'd600;
   localparam logic [7:0]  CAPS_USAGE   = 8'h39;
   localparam logic [7:0]  REBOOT_USAGE = 8'h15;
   localparam logic [7:0]  TERM_USAGE   = 8'h17;
   localparam logic [7:0]  SHIFT_MASK   = 8'h22;
   localparam logic [7:0]  CTRL_MASK    = 8'h11;

   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [2:0] {
      EV_DOWN   = 3'd0,
      EV_REPEAT = 3'd1,
      EV_UP     = 3'd2,
      EV_CHAR   = 3'd3,
      EV_TERM   = 3'd4,
      EV_REBOOT = 3'd5
   } event_kind_type;

   typedef struct packed {
      logic           valid;
      event_kind_type kind;
      logic [7:0]     code;
   } emit_type;

   localparam logic [7:0] USAGE_MAP [256] = '{
      8'd0,8'd0,8'd0,8'd0,8'd30,8'd48,8'd46,8'd32,8'd18,8'd33,8'd34,8'd35,8'd23,8'd36,8'd37,8'd38,
      8'd50,8'd49,8'd24,8'd25,8'd16,8'd19,8'd31,8'd20,8'd22,8'd47,8'd17,8'd45,8'd21,8'd44,8'd2,8'd3,
      8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,8'd10,8'd11,8'd28,8'd1,8'd14,8'd15,8'd57,8'd12,8'd13,8'd26,
      8'd27,8'd43,8'd0,8'd39,8'd40,8'd41,8'd51,8'd52,8'd43,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,
      8'd65,8'd66,8'd67,8'd68,8'd87,8'd88,8'd196,8'd70,8'd197,8'd198,8'd199,8'd201,8'd211,8'd207,
      8'd209,8'd205,
      8'd203,8'd208,8'd200,8'd69,8'd181,8'd55,8'd74,8'd78,8'd156,8'd79,8'd80,8'd81,8'd75,8'd76,
      8'd77,8'd71,
      8'd72,8'd73,8'd82,8'd83,8'd43,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
      8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
      8'd0,8'd0,8'd0,8'd0,8'd0,8'd179,8'd141,8'd0,8'd112,8'd125,8'd121,8'd123,8'd0,8'd0,8'd0,8'd0,
      8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
      8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
      8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
      8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
      8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
      8'd29,8'd42,8'd56,8'd91,8'd157,8'd54,8'd184,8'd92,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
      8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0
   };

   localparam logic [7:0] MOD_MAP [8] = '{
      8'd29, 8'd42, 8'd56, 8'd91, 8'd157, 8'd54, 8'd184, 8'd92
   };

   localparam logic [7:0] DIGIT_SHIFT [10] = '{
      8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29
   };
   localparam logic [7:0] PUNCT_LO [13] = '{
      8'h20, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h23, 8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E, 8'h2F
   };
   localparam logic [7:0] PUNCT_HI [13] = '{
      8'h20, 8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C, 8'h7E, 8'h3A, 8'h22, 8'h7E, 8'h3C, 8'h3E, 8'h3F
   };
   localparam logic [7:0] PAD_LO [20] = '{
      8'h2F, 8'h2A, 8'h2D, 8'h2B, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
      8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h3D
   };
   localparam logic [7:0] PAD_HI [20] = '{
      8'h2F, 8'h2A, 8'h2D, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h35,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3D
   };

   // ascii of a usage code, unshifted or shifted column, zero if none
   function automatic logic [7:0] ascii_of(input logic [7:0] k, input logic hi);
      logic [7:0] d_let;
      logic [7:0] d_dig;
      logic [7:0] d_pun;
      logic [7:0] d_pad;
      logic [7:0] r;
      d_let = k - 8'h04;
      d_dig = k - 8'h1E;
      d_pun = k - 8'h2C;
      d_pad = k - 8'h54;
      r = 8'h00;
      if (k >= 8'h04 && k <= 8'h1D) begin
         r = (hi ? 8'h41 : 8'h61) + d_let;
      end else if (k >= 8'h1E && k <= 8'h27) begin
         if (hi) begin
            r = DIGIT_SHIFT[d_dig[3:0]];
         end else begin
            r = (k == 8'h27) ? 8'h30 : 8'h31 + d_dig;
         end
      end else if (k >= 8'h2C && k <= 8'h38) begin
         r = hi ? PUNCT_HI[d_pun[3:0]] : PUNCT_LO[d_pun[3:0]];
      end else if (k >= 8'h54 && k <= 8'h67) begin
         r = hi ? PAD_HI[d_pad[4:0]] : PAD_LO[d_pad[4:0]];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/kred_out_stage.sv -----
// result output stage: holds one result back so the final one can be marked
// depends on kred_pkg
`default_nettype none

module kred_out_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire kred_pkg::emit_type emit,
   input  wire logic               flush,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_event_kind,
   output logic [7:0]              rsp_event_code,
   output logic                    rsp_last_of_run
);

   kred_pkg::emit_type pend_ff;
   logic               valid_ff;
   logic [2:0]         kind_ff;
   logic [7:0]         code_ff;
   logic               last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff.valid <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         if (emit.valid) begin
            // a newer result shows the held one is not the last
            valid_ff <= pend_ff.valid;
            kind_ff  <= pend_ff.kind;
            code_ff  <= pend_ff.code;
            last_ff  <= 1'b0;
            pend_ff  <= emit;
         end else if (flush) begin
            valid_ff      <= pend_ff.valid;
            kind_ff       <= pend_ff.kind;
            code_ff       <= pend_ff.code;
            last_ff       <= 1'b1;
            pend_ff.valid <= 1'b0;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_event_code  = code_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

// ----- hdl/keyboard_report_event_decoder.sv -----
// top level of the keyboard report event decoder: sequencer and press-time memory
// depends on kred_pkg and kred_out_stage
`default_nettype none

// Decodes boot keyboard reports and repeat timer ticks into key, character and
// shortcut events. An item is taken when start is high and busy is low; busy
// then stays high until the item's last result has reached the output register,
// and that last result shows on the ports in the cycle in which busy falls.
// Results leave one per strobe on rsp_valid, at most one a cycle, and cannot be
// stalled; the last result of an item carries rsp_last_of_run. One sequencer
// walks the work one step a cycle through a single press-time memory with one
// read and one write port, and one expiry compare (32-bit subtract and compare
// against delay_ff). A report steps each slot through a read, an event and,
// where due, a character step, then each modifier bit, each previous slot and
// a flush step. A tick checks the reboot and terminate shortcuts first when
// ctrl is held, then reads and checks each key code with a character step per
// repeated character, and ends in a flush step. After reset a clearing pass
// zeroes the press-time memory while busy is high; csr writes are taken always.
module keyboard_report_event_decoder #(
   parameter int KEY_CODES = kred_pkg::KEY_CODES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_modifier_bits,
   input  wire logic [7:0]  req_slot_key0,
   input  wire logic [7:0]  req_slot_key1,
   input  wire logic [7:0]  req_slot_key2,
   input  wire logic [7:0]  req_slot_key3,
   input  wire logic [7:0]  req_slot_key4,
   input  wire logic [7:0]  req_slot_key5,
   input  wire logic [31:0] req_now_ms,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   output logic             rsp_valid,
   output logic [2:0]       rsp_event_kind,
   output logic [7:0]       rsp_event_code,
   output logic             rsp_last_of_run
);

   localparam int ADDR_W = $clog2(KEY_CODES);
   localparam int SCAN_W = $clog2(KEY_CODES + 1);
   localparam int SLOT_W = $clog2(kred_pkg::KEY_SLOTS);
   localparam int CNT_W  = $clog2(kred_pkg::MAX_RESULTS + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE,
      S_NEW_RD, S_NEW_EV, S_NEW_CHAR,
      S_MOD, S_REL,
      S_RBT_RD, S_RBT_EV, S_TRM_RD, S_TRM_EV,
      S_SCAN_RD, S_SCAN_EV, S_SCAN_CHAR,
      S_FLUSH
   } state_type;

   state_type   state_ff;
   logic [15:0] delay_ff;
   logic [7:0]  keys_ff [kred_pkg::KEY_SLOTS];
   logic [7:0]  prev_keys_ff [kred_pkg::KEY_SLOTS];
   logic [7:0]  mods_ff;
   logic [7:0]  prev_mods_ff;
   logic [31:0] now_ff;
   logic        caps_ff;
   logic        shift_ff;
   logic        ctrl_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [2:0]  bit_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic [SCAN_W-1:0] clr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [7:0]  char_ff;

   // press-time memory, one read and one write port
   logic [31:0] press_mem [KEY_CODES];
   logic [31:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic        wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [31:0] wr_data;

   // per-step decode of the key under work
   logic [7:0]  cur_key;
   logic        in_range;
   logic [31:0] held;
   logic [31:0] elapsed;
   logic        expired;
   logic [7:0]  map_code;
   logic [7:0]  asc_lo;
   logic        shift_now;
   logic        upper_rpt;
   logic        upper_tick;
   logic        in_report;
   logic        is_new;
   logic        is_gone;
   logic        last_slot;

   kred_pkg::emit_type want;
   kred_pkg::emit_type emit;
   logic               flush;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      unique case (state_ff)
         S_REL:                cur_key = prev_keys_ff[slot_ff];
         S_RBT_RD, S_RBT_EV:   cur_key = kred_pkg::REBOOT_USAGE;
         S_TRM_RD, S_TRM_EV:   cur_key = kred_pkg::TERM_USAGE;
         S_SCAN_RD, S_SCAN_EV, S_SCAN_CHAR: cur_key = scan_ff[7:0];
         default:              cur_key = keys_ff[slot_ff];
      endcase
   end

   // codes past the memory have no press time and no mapping
   assign in_range   = ({1'b0, cur_key} < 9'(KEY_CODES));
   assign held       = in_range ? rd_data_ff : 32'd0;
   assign elapsed    = now_ff - held;
   assign expired    = (held != 32'd0) && (elapsed > {16'd0, delay_ff});
   assign map_code   = in_range ? kred_pkg::USAGE_MAP[cur_key] : 8'd0;
   assign asc_lo     = kred_pkg::ascii_of(cur_key, 1'b0);
   assign shift_now  = |(mods_ff & kred_pkg::SHIFT_MASK);
   assign upper_rpt  = shift_now ^ caps_ff;
   assign upper_tick = shift_ff ^ caps_ff;
   assign is_new     = (cur_key != 8'd0) && (held == 32'd0);
   assign is_gone    = (cur_key != 8'd0) && !in_report;
   assign last_slot  = (slot_ff == SLOT_W'(kred_pkg::KEY_SLOTS - 1));

   always_comb begin
      in_report = 1'b0;
      for (int i = 0; i < kred_pkg::KEY_SLOTS; i++) begin
         if (keys_ff[i] == cur_key) in_report = 1'b1;
      end
   end

   assign rd_addr = cur_key[ADDR_W-1:0];

   // memory writes and result requests of the current step
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = cur_key[ADDR_W-1:0];
      wr_data    = 32'd0;
      want.valid = 1'b0;
      want.kind  = kred_pkg::EV_DOWN;
      want.code  = 8'd0;
      flush      = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[ADDR_W-1:0];
         end
         S_NEW_EV: begin
            if (is_new) begin
               wr_en      = in_range;
               wr_data    = now_ff;
               want.valid = (map_code != 8'd0);
               want.code  = map_code;
            end
         end
         S_NEW_CHAR: begin
            want.valid = 1'b1;
            want.kind  = kred_pkg::EV_CHAR;
            want.code  = char_ff;
         end
         S_MOD: begin
            want.valid = mods_ff[bit_ff] ^ prev_mods_ff[bit_ff];
            want.kind  = mods_ff[bit_ff] ? kred_pkg::EV_DOWN : kred_pkg::EV_UP;
            want.code  = kred_pkg::MOD_MAP[bit_ff];
         end
         S_REL: begin
            if (is_gone) begin
               wr_en      = in_range;
               want.valid = (map_code != 8'd0);
               want.kind  = kred_pkg::EV_UP;
               want.code  = map_code;
            end
         end
         S_RBT_EV: begin
            want.valid = expired;
            want.kind  = kred_pkg::EV_REBOOT;
         end
         S_TRM_EV: begin
            // terminate clears the key's press time when it fires
            want.valid = expired;
            want.kind  = kred_pkg::EV_TERM;
            wr_en      = expired && in_range;
         end
         S_SCAN_EV: begin
            want.valid = (map_code != 8'd0) && expired;
            want.kind  = kred_pkg::EV_REPEAT;
            want.code  = map_code;
         end
         S_SCAN_CHAR: begin
            want.valid = 1'b1;
            want.kind  = kred_pkg::EV_CHAR;
            want.code  = char_ff;
         end
         S_FLUSH: begin
            flush = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // results past the per-item limit are dropped
   always_comb begin
      emit       = want;
      emit.valid = want.valid && (cnt_ff < CNT_W'(kred_pkg::MAX_RESULTS));
   end

   always_ff @(posedge clock) begin
      if (wr_en) press_mem[wr_addr] <= wr_data;
      rd_data_ff <= press_mem[rd_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         delay_ff     <= kred_pkg::DELAY_RESET;
         prev_mods_ff <= 8'd0;
         caps_ff      <= 1'b0;
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         cnt_ff       <= '0;
         slot_ff      <= '0;
         bit_ff       <= 3'd0;
         scan_ff      <= '0;
         for (int i = 0; i < kred_pkg::KEY_SLOTS; i++) prev_keys_ff[i] <= 8'd0;
      end else begin
         if (csr_wr_en) delay_ff <= csr_wr_data;
         if (emit.valid) cnt_ff <= cnt_ff + CNT_W'(1);
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + SCAN_W'(1);
               if (clr_ff == SCAN_W'(KEY_CODES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  keys_ff[0] <= req_slot_key0;
                  keys_ff[1] <= req_slot_key1;
                  keys_ff[2] <= req_slot_key2;
                  keys_ff[3] <= req_slot_key3;
                  keys_ff[4] <= req_slot_key4;
                  keys_ff[5] <= req_slot_key5;
                  mods_ff    <= req_modifier_bits;
                  now_ff     <= req_now_ms;
                  cnt_ff     <= '0;
                  slot_ff    <= '0;
                  bit_ff     <= 3'd0;
                  scan_ff    <= '0;
                  if (req_operation == kred_pkg::OP_TICK) begin
                     state_ff <= ctrl_ff ? S_RBT_RD : S_SCAN_RD;
                  end else begin
                     state_ff <= S_NEW_RD;
                  end
               end
            end
            S_NEW_RD: state_ff <= S_NEW_EV;
            S_NEW_EV: begin
               if (is_new && cur_key == kred_pkg::CAPS_USAGE) caps_ff <= !caps_ff;
               char_ff <= kred_pkg::ascii_of(cur_key, upper_rpt);
               if (is_new && map_code != 8'd0 && asc_lo != 8'd0) begin
                  state_ff <= S_NEW_CHAR;
               end else if (last_slot) begin
                  state_ff <= S_MOD;
               end else begin
                  slot_ff  <= slot_ff + SLOT_W'(1);
                  state_ff <= S_NEW_RD;
               end
            end
            S_NEW_CHAR: begin
               if (last_slot) begin
                  state_ff <= S_MOD;
               end else begin
                  slot_ff  <= slot_ff + SLOT_W'(1);
                  state_ff <= S_NEW_RD;
               end
            end
            S_MOD: begin
               bit_ff <= bit_ff + 3'd1;
               if (bit_ff == 3'd7) begin
                  shift_ff <= shift_now;
                  ctrl_ff  <= |(mods_ff & kred_pkg::CTRL_MASK);
                  slot_ff  <= '0;
                  state_ff <= S_REL;
               end
            end
            S_REL: begin
               if (last_slot) begin
                  for (int i = 0; i < kred_pkg::KEY_SLOTS; i++) prev_keys_ff[i] <= keys_ff[i];
                  prev_mods_ff <= mods_ff;
                  state_ff     <= S_FLUSH;
               end else begin
                  slot_ff <= slot_ff + SLOT_W'(1);
               end
            end
            S_RBT_RD: state_ff <= S_RBT_EV;
            S_RBT_EV: state_ff <= S_TRM_RD;
            S_TRM_RD: state_ff <= S_TRM_EV;
            S_TRM_EV: state_ff <= S_SCAN_RD;
            S_SCAN_RD: state_ff <= S_SCAN_EV;
            S_SCAN_EV: begin
               char_ff <= kred_pkg::ascii_of(cur_key, upper_tick);
               if (map_code != 8'd0 && expired && asc_lo != 8'd0) begin
                  state_ff <= S_SCAN_CHAR;
               end else if (scan_ff == SCAN_W'(KEY_CODES - 1)) begin
                  state_ff <= S_FLUSH;
               end else begin
                  scan_ff  <= scan_ff + SCAN_W'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SCAN_CHAR: begin
               if (scan_ff == SCAN_W'(KEY_CODES - 1)) begin
                  state_ff <= S_FLUSH;
               end else begin
                  scan_ff  <= scan_ff + SCAN_W'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_FLUSH: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result transfer stage
   kred_out_stage u_out (
      .clock           (clock),
      .reset           (reset),
      .emit            (emit),
      .flush           (flush),
      .rsp_valid       (rsp_valid),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_code  (rsp_event_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ----- hdl/kred_checker.sv -----
// port-level checks of the keyboard report event decoder, bound to the top level
// depends on kred_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module kred_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [2:0] rsp_event_kind,
   input wire logic [7:0] rsp_event_code,
   input wire logic       rsp_last_of_run
);

   logic last_out;
   logic req_kind;

   assign last_out = rsp_valid && rsp_last_of_run;
   assign req_kind = (rsp_event_kind == kred_pkg::EV_TERM) ||
                     (rsp_event_kind == kred_pkg::EV_REBOOT);

   `ASSERT_CLK(a_accept_busy, clock, reset, (start && !busy) |=> busy, "busy not set")
   `ASSERT_CLK(a_rsp_in_item, clock, reset, rsp_valid |-> $past(busy), "result outside item")
   `ASSERT_CLK(a_last_gap, clock, reset, last_out |=> !rsp_valid, "result after last")
   `ASSERT_NEVER(a_req_code, clock, reset, rsp_valid && req_kind && rsp_event_code != 8'd0, "code")

endmodule

bind keyboard_report_event_decoder kred_checker u_kred_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_event_code  (rsp_event_code),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench for keyboard_report_event_decoder
// depends on kred_pkg and the decoder rtl; a scoreboard class predicts every event
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE = 700;   // a tick walks every key code

   // predicts the events of each accepted report or tick and checks them in order
   class event_scoreboard;
      typedef struct {
         kred_pkg::event_kind_type kind;
         bit [7:0]                 code;
         bit                       last;
      } key_event_type;

      // key codes for usages 0x00..0x67; the rest is decoded in key_code
      localparam bit [7:0] LOW_MAP [104] = '{
         0,0,0,0,30,48,46,32,18,33,34,35,23,36,37,38,
         50,49,24,25,16,19,31,20,22,47,17,45,21,44,2,3,
         4,5,6,7,8,9,10,11,28,1,14,15,57,12,13,26,
         27,43,0,39,40,41,51,52,43,58,59,60,61,62,63,64,
         65,66,67,68,87,88,196,70,197,198,199,201,211,207,209,205,
         203,208,200,69,181,55,74,78,156,79,80,81,75,76,77,71,
         72,73,82,83,43,0,0,0
      };
      localparam bit [7:0] MOD_CODE [8] = '{29, 42, 56, 91, 157, 54, 184, 92};

      key_event_type events_due[$];
      key_event_type this_run[$];
      int         errors;
      bit [31:0]  press_ms [256];
      bit [7:0]   held_keys [6];
      bit [7:0]   held_mods;
      bit         caps, shift_down, ctrl_down;
      bit [15:0]  delay_ms;

      function new();
         errors = 0;
         foreach (press_ms[i]) press_ms[i] = '0;
         foreach (held_keys[i]) held_keys[i] = '0;
         held_mods = '0;
         caps = 0;
         shift_down = 0;
         ctrl_down = 0;
         delay_ms = 16'd600;
      endfunction

      function bit [7:0] key_code(bit [7:0] k);
         if (k < 104) return LOW_MAP[k];
         if (k >= 8'hE0 && k <= 8'hE7) return MOD_CODE[k - 8'hE0];
         case (k)
            8'h85: return 8'd179;
            8'h86: return 8'd141;
            8'h88: return 8'd112;
            8'h89: return 8'd125;
            8'h8A: return 8'd121;
            8'h8B: return 8'd123;
            default: return 8'd0;
         endcase
      endfunction

      // ascii of a usage, spaces in the keypad strings stand for no character
      function bit [7:0] char_of(bit [7:0] k, bit hi);
         string digit_hi = "!@#$%^&*()";
         string punct_lo = " -=[]\\#;'`,./";
         string punct_hi = " _+{}|~:\"~<>?";
         string pad_lo = "/*-+ 1234567890.   =";
         string pad_hi = "/*-+     5         =";
         byte c;
         if (k >= 8'h04 && k <= 8'h1D) return (hi ? 8'h41 : 8'h61) + (k - 8'h04);
         if (k >= 8'h1E && k <= 8'h27) begin
            if (hi) return digit_hi[k - 8'h1E];
            return (k == 8'h27) ? 8'h30 : 8'h31 + (k - 8'h1E);
         end
         if (k >= 8'h2C && k <= 8'h38) return hi ? punct_hi[k - 8'h2C] : punct_lo[k - 8'h2C];
         if (k >= 8'h54 && k <= 8'h67) begin
            c = hi ? pad_hi[k - 8'h54] : pad_lo[k - 8'h54];
            return (c == " ") ? 8'h00 : c;
         end
         return 8'h00;
      endfunction

      function void add(kred_pkg::event_kind_type kind, bit [7:0] code);
         key_event_type e;
         e.kind = kind;
         e.code = code;
         e.last = 0;
         if (this_run.size() < kred_pkg::MAX_RESULTS) this_run.push_back(e);
      endfunction

      function void add_char(bit [7:0] k, bit upper);
         if (char_of(k, 1'b0) != 0) add(kred_pkg::EV_CHAR, char_of(k, upper));
      endfunction

      function bit expired(bit [7:0] k, bit [31:0] now);
         bit [31:0] held;
         held = now - press_ms[k];
         return press_ms[k] != 0 && held > {16'd0, delay_ms};
      endfunction

      function void decode_report(bit [7:0] mods, bit [7:0] keys [6], bit [31:0] now);
         bit shift_now;
         bit found;
         bit [7:0] diff;
         shift_now = (mods & kred_pkg::SHIFT_MASK) != 0;
         // new presses in slot order; a duplicate is new only once
         for (int i = 0; i < 6; i++) begin
            if (keys[i] != 0 && press_ms[keys[i]] == 0) begin
               if (key_code(keys[i]) != 0) begin
                  add(kred_pkg::EV_DOWN, key_code(keys[i]));
                  add_char(keys[i], shift_now != caps);
               end
               if (keys[i] == kred_pkg::CAPS_USAGE) caps = !caps;
               press_ms[keys[i]] = now;
            end
         end
         diff = mods ^ held_mods;
         for (int b = 0; b < 8; b++)
            if (diff[b]) add(mods[b] ? kred_pkg::EV_DOWN : kred_pkg::EV_UP, MOD_CODE[b]);
         shift_down = shift_now;
         ctrl_down = (mods & kred_pkg::CTRL_MASK) != 0;
         // releases: every old slot whose code is gone
         for (int i = 0; i < 6; i++) begin
            found = 0;
            for (int j = 0; j < 6; j++) if (keys[j] == held_keys[i]) found = 1;
            if (held_keys[i] != 0 && !found) begin
               if (key_code(held_keys[i]) != 0) add(kred_pkg::EV_UP, key_code(held_keys[i]));
               press_ms[held_keys[i]] = 0;
            end
         end
         held_keys = keys;
         held_mods = mods;
      endfunction

      function void decode_tick(bit [31:0] now);
         if (ctrl_down) begin
            if (expired(kred_pkg::REBOOT_USAGE, now)) add(kred_pkg::EV_REBOOT, 8'h00);
            if (expired(kred_pkg::TERM_USAGE, now)) begin
               add(kred_pkg::EV_TERM, 8'h00);
               press_ms[kred_pkg::TERM_USAGE] = 0;
            end
         end
         for (int k = 0; k < 256; k++) begin
            if (key_code(k) != 0 && expired(k, now)) begin
               add(kred_pkg::EV_REPEAT, key_code(k));
               add_char(k, shift_down != caps);
            end
         end
      endfunction

      // one accepted transfer: queue its events behind those still due
      function void note_item(bit op, bit [7:0] mods, bit [7:0] keys [6], bit [31:0] now);
         this_run.delete();
         if (op == kred_pkg::OP_TICK) decode_tick(now);
         else decode_report(mods, keys, now);
         if (this_run.size() > 0) this_run[$].last = 1;
         foreach (this_run[i]) events_due.push_back(this_run[i]);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_event(bit [2:0] kind, bit [7:0] code, bit last);
         key_event_type e;
         if (events_due.size() == 0) begin
            report($sformatf("unexpected event kind %0d code %0d", kind, code));
         end else begin
            e = events_due.pop_front();
            if (kind != e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
            if (code != e.code) report($sformatf("code %0d, want %0d", code, e.code));
            if (last != e.last) report($sformatf("last_of_run %0d, want %0d", last, e.last));
         end
      endtask

      function int pending();
         return events_due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [7:0]  req_modifier_bits;
   logic [7:0]  req_slot_key0, req_slot_key1, req_slot_key2;
   logic [7:0]  req_slot_key3, req_slot_key4, req_slot_key5;
   logic [31:0] req_now_ms;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        rsp_valid;
   logic [2:0]  rsp_event_kind;
   logic [7:0]  rsp_event_code;
   logic        rsp_last_of_run;

   event_scoreboard sb = new();
   int unsigned     cycles = 0;
   bit [31:0]       now_ms;       // running time base of the stimulus
   bit [7:0]        keys [6];
   bit [7:0]        mods;

   keyboard_report_event_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_modifier_bits(req_modifier_bits),
      .req_slot_key0    (req_slot_key0),
      .req_slot_key1    (req_slot_key1),
      .req_slot_key2    (req_slot_key2),
      .req_slot_key3    (req_slot_key3),
      .req_slot_key4    (req_slot_key4),
      .req_slot_key5    (req_slot_key5),
      .req_now_ms       (req_now_ms),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_code   (rsp_event_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // results cannot be held off: every strobe is a transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_event(rsp_event_kind, rsp_event_code, rsp_last_of_run);
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // drive one item and hold start until the block takes it
   task automatic send_item(bit op, bit [7:0] m, bit [7:0] k [6], bit [31:0] t);
      req_operation <= op;
      req_modifier_bits <= m;
      req_slot_key0 <= k[0];
      req_slot_key1 <= k[1];
      req_slot_key2 <= k[2];
      req_slot_key3 <= k[3];
      req_slot_key4 <= k[4];
      req_slot_key5 <= k[5];
      req_now_ms <= t;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_item(op, m, k, t);
   endtask

   task automatic report_keys(bit [7:0] m, bit [7:0] k0, bit [7:0] k1, bit [7:0] k2,
                              bit [7:0] k3, bit [7:0] k4, bit [7:0] k5, bit [31:0] t);
      bit [7:0] k [6];
      k = '{k0, k1, k2, k3, k4, k5};
      send_item(kred_pkg::OP_REPORT, m, k, t);
   endtask

   task automatic tick(bit [31:0] t);
      bit [7:0] k [6];
      k = '{default: 8'h00};
      send_item(kred_pkg::OP_TICK, 8'h00, k, t);
   endtask

   // random pause of the sender; at least a quarter of the items go back to back
   task automatic sender_gap();
      int g;
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // let every expected event arrive, then let a silent tick finish
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_delay(bit [15:0] v);
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.delay_ms = v;
   endtask

   // usage codes weighted toward keys with a mapping and a character
   function automatic bit [7:0] pick_usage();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(8'h04, 8'h67);
         5: return $urandom_range(8'hE0, 8'hE7);
         6: begin
            case ($urandom_range(0, 2))
               0: return kred_pkg::CAPS_USAGE;
               1: return kred_pkg::REBOOT_USAGE;
               default: return kred_pkg::TERM_USAGE;
            endcase
         end
         7: return 8'h00;
         8: return $urandom_range(0, 255);
         default: return $urandom_range(8'h68, 8'hFF);
      endcase
   endfunction

   // one random transfer: mostly evolving key sets, some ticks, a little noise
   task automatic random_item();
      int sel;
      sel = $urandom_range(0, 99);
      // steps around the delay so repeats fire and also miss
      if ($urandom_range(0, 30) == 0) now_ms = now_ms + $urandom;
      else now_ms = now_ms + $urandom_range(1, 2 * sb.delay_ms + 40);
      if (sel < 32) begin
         tick(now_ms);
      end else if (sel < 37) begin
         foreach (keys[i]) keys[i] = $urandom_range(0, 255);
         mods = $urandom_range(0, 255);
         send_item(kred_pkg::OP_REPORT, mods, keys, now_ms);
      end else begin
         foreach (keys[i]) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: ;
               11, 12, 13, 14, 15: keys[i] = pick_usage();
               default: keys[i] = 8'h00;
            endcase
         end
         mods = mods ^ ($urandom_range(0, 255) & $urandom_range(0, 255));
         send_item(kred_pkg::OP_REPORT, mods, keys, now_ms);
      end
      sender_gap();
   endtask

   initial begin
      bit [15:0] settings [5];

      reset <= 1'b1;
      start <= 1'b0;
      req_operation <= kred_pkg::OP_REPORT;
      req_modifier_bits <= '0;
      req_slot_key0 <= '0;
      req_slot_key1 <= '0;
      req_slot_key2 <= '0;
      req_slot_key3 <= '0;
      req_slot_key4 <= '0;
      req_slot_key5 <= '0;
      req_now_ms <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset delay of 600 ms
      // press at time zero is stored as not held, so it is new again next report
      report_keys(8'h00, 8'h04, 0, 0, 0, 0, 0, 32'd0);
      // duplicate slots and shifted letter
      report_keys(8'h02, 8'h04, 8'h04, 0, 0, 0, 0, 32'd100);
      // caps lock toggles before the later slot picks its case
      report_keys(8'h02, 8'h04, 8'h39, 8'h05, 0, 0, 0, 32'd200);
      tick(32'd800);
      tick(32'd900);
      // ctrl held with reboot and terminate keys
      report_keys(8'h11, 8'h15, 8'h17, 0, 0, 0, 0, 32'd1000);
      tick(32'd1600);
      tick(32'd1601);
      tick(32'd1700);
      // all modifiers, codes past the ascii table, keys with no mapping
      report_keys(8'hFF, 8'hFF, 8'h68, 8'h85, 8'h88, 8'hE0, 8'h58, 32'd2000);
      tick(32'd2700);
      // keypad and punctuation with caps on, shifted and not
      report_keys(8'h00, 8'h54, 8'h58, 8'h5D, 8'h63, 8'h62, 8'h67, 32'd3000);
      report_keys(8'h20, 8'h1E, 8'h27, 8'h2C, 8'h31, 8'h38, 8'h2D, 32'd3100);
      tick(32'd3800);
      report_keys(8'h00, 0, 0, 0, 0, 0, 0, 32'd4000);
      report_keys(8'h00, 8'h39, 0, 0, 0, 0, 0, 32'd4100);
      report_keys(8'h22, 8'h1D, 8'h34, 8'h60, 0, 0, 0, 32'd4200);
      report_keys(8'h00, 0, 0, 0, 0, 0, 0, 32'd4300);
      // held time across the wrap of the millisecond counter
      report_keys(8'h00, 8'h04, 0, 0, 0, 0, 0, 32'hFFFF_FF00);
      tick(32'h0000_0100);
      tick(32'h0000_0300);
      tick(32'hFFFF_FFFF);
      report_keys(8'h00, 0, 0, 0, 0, 0, 0, 32'h0000_0400);
      now_ms = 32'h0000_0500;
      mods = '0;
      keys = '{default: 8'h00};

      // random phases over several delay settings, extremes included
      settings = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 2000)), 16'd600};
      foreach (settings[p]) begin
         drain();
         write_delay(settings[p]);
         for (int n = 0; n < 78; n++) random_item();
      end

      drain();
      if (sb.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
